[hw/rtl/suis_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suis_pkg: shared types and constants for the sorted unique ID set
// Sizes, operation codes, transaction payload structs and the RAM request
// bundle used between the sequencer and the top level.
// ----------------------------------------------------------------------------
package suis_pkg;

    // Sizes
    localparam int CAPACITY  = 256;
    localparam int ID_BITS   = 16;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int ADDR_W    = IDX_W + 1;
    localparam int RAM_DEPTH = 2 << IDX_W;

    // Field widths fixed by the interface
    localparam int OP_W    = 2;
    localparam int ITEM_W  = 16;
    localparam int LCOUNT_W = 9;

    // Operation codes
    localparam logic [OP_W-1:0] OP_MARK  = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // List select codes
    localparam logic SEL_WAVE = 1'b0;
    localparam logic SEL_PCM  = 1'b1;

    // Request transaction
    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic              list_select;
        logic [ITEM_W-1:0] item_id;
    } req_t;

    // Response transaction
    typedef struct packed {
        logic                was_present;
        logic                inserted;
        logic                full_error;
        logic [LCOUNT_W-1:0] list_count;
    } rsp_t;

    // RAM access bundle from the sequencer
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [ID_BITS-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

endpackage

[hw/rtl/suis_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suis_ram: simple dual-port RAM
// One write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module suis_ram #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/suis_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suis_ctrl: search and insert sequencer
// Binary search over the selected list with one shared comparator, then, for a mark of
// a new ID, an upward shift of later entries one word at a time and the insert.
// ----------------------------------------------------------------------------
module suis_ctrl
    import suis_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  req_t               req,
    output logic               req_stall,
    output ram_req_t           ram_req,
    input  logic [ID_BITS-1:0] ram_rdata,
    output logic               res_valid,
    output rsp_t               res,
    input  logic               res_ready
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SRCH  = 7'b0000010,
        S_CMP   = 7'b0000100,
        S_SH_RD = 7'b0001000,
        S_SH_WR = 7'b0010000,
        S_INS   = 7'b0100000,
        S_RESP  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [OP_W-1:0]    op_reg, op_next;
    logic               sel_reg, sel_next;
    logic [ID_BITS-1:0] id_reg, id_next;
    logic [CNT_W-1:0]   lo_reg, lo_next;
    logic [CNT_W-1:0]   hi_reg, hi_next;
    logic [CNT_W-1:0]   pos_reg, pos_next;
    logic               present_reg, present_next;
    logic               ins_reg, ins_next;
    logic               full_reg, full_next;
    logic [CNT_W-1:0]   wave_count_reg, wave_count_next;
    logic [CNT_W-1:0]   pcm_count_reg, pcm_count_next;

    logic [31:0]        item_ext;
    logic [ID_BITS-1:0] in_id;
    logic [CNT_W-1:0]   in_count;
    logic [CNT_W-1:0]   cnt_sel;
    logic [CNT_W:0]     mid_sum;
    logic [CNT_W-1:0]   mid;
    logic [CNT_W-1:0]   hi_dec;
    logic [31:0]        cnt_ext;
    logic               id_lt;
    logic               id_eq;

    // Incoming ID masked to ID_BITS
    assign item_ext = {{(32 - ITEM_W){1'b0}}, req.item_id};
    assign in_id    = item_ext[ID_BITS-1:0];
    assign in_count = (req.list_select == SEL_PCM) ? pcm_count_reg : wave_count_reg;
    assign cnt_sel  = (sel_reg == SEL_PCM) ? pcm_count_reg : wave_count_reg;

    // Midpoint and shift index arithmetic
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[CNT_W:1];
    assign hi_dec  = hi_reg - {{(CNT_W - 1){1'b0}}, 1'b1};

    // Shared comparator
    assign id_lt = id_reg < ram_rdata;
    assign id_eq = id_reg == ram_rdata;

    assign req_stall = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_RESP);

    // Response fields
    assign cnt_ext         = {{(32 - CNT_W){1'b0}}, cnt_sel};
    assign res.was_present = present_reg;
    assign res.inserted    = ins_reg;
    assign res.full_error  = full_reg;
    assign res.list_count  = cnt_ext[LCOUNT_W-1:0];

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        sel_next        = sel_reg;
        id_next         = id_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        pos_next        = pos_reg;
        present_next    = present_reg;
        ins_next        = ins_reg;
        full_next       = full_reg;
        wave_count_next = wave_count_reg;
        pcm_count_next  = pcm_count_reg;
        ram_req.we      = 1'b0;
        ram_req.waddr   = {sel_reg, hi_reg[IDX_W-1:0]};
        ram_req.wdata   = ram_rdata;
        ram_req.raddr   = {sel_reg, mid[IDX_W-1:0]};

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next      = req.operation;
                    sel_next     = req.list_select;
                    id_next      = in_id;
                    lo_next      = '0;
                    hi_next      = in_count;
                    present_next = 1'b0;
                    ins_next     = 1'b0;
                    full_next    = 1'b0;
                    state_next   = S_RESP;
                    if (req.operation == OP_CLEAR)
                    begin
                        wave_count_next = '0;
                        pcm_count_next  = '0;
                    end
                    else if ((req.operation inside {OP_MARK, OP_QUERY}) && in_id != '0)
                    begin
                        state_next = S_SRCH;
                    end
                end
            end

            // Issue a read at the midpoint, or finish the search
            S_SRCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    pos_next   = mid;
                    state_next = S_CMP;
                end
                else
                begin
                    pos_next = lo_reg;
                    if (op_reg != OP_MARK)
                    begin
                        state_next = S_RESP;
                    end
                    else if (cnt_sel >= CNT_W'(CAPACITY))
                    begin
                        full_next  = 1'b1;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        hi_next    = cnt_sel;
                        state_next = S_SH_RD;
                    end
                end
            end

            // Narrow the range on the read word
            S_CMP:
            begin
                if (id_eq)
                begin
                    present_next = 1'b1;
                    state_next   = S_RESP;
                end
                else if (id_lt)
                begin
                    hi_next    = pos_reg;
                    state_next = S_SRCH;
                end
                else
                begin
                    lo_next    = pos_reg + {{(CNT_W - 1){1'b0}}, 1'b1};
                    state_next = S_SRCH;
                end
            end

            // Read entry j-1 while j is above the insert point
            S_SH_RD:
            begin
                ram_req.raddr = {sel_reg, hi_dec[IDX_W-1:0]};
                if (hi_reg > pos_reg)
                begin
                    state_next = S_SH_WR;
                end
                else
                begin
                    state_next = S_INS;
                end
            end

            // Move it up into entry j
            S_SH_WR:
            begin
                ram_req.we = 1'b1;
                hi_next    = hi_dec;
                state_next = S_SH_RD;
            end

            S_INS:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = {sel_reg, pos_reg[IDX_W-1:0]};
                ram_req.wdata = id_reg;
                ins_next      = 1'b1;
                if (sel_reg == SEL_PCM)
                begin
                    pcm_count_next = pcm_count_reg + {{(CNT_W - 1){1'b0}}, 1'b1};
                end
                else
                begin
                    wave_count_next = wave_count_reg + {{(CNT_W - 1){1'b0}}, 1'b1};
                end
                state_next = S_RESP;
            end

            S_RESP:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            wave_count_reg <= '0;
            pcm_count_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            wave_count_reg <= wave_count_next;
            pcm_count_reg  <= pcm_count_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        sel_reg     <= sel_next;
        id_reg      <= id_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        pos_reg     <= pos_next;
        present_reg <= present_next;
        ins_reg     <= ins_next;
        full_reg    <= full_next;
    end

endmodule

[hw/rtl/sorted_unique_id_set_unit.sv]
`timescale 1ns / 1ps
// Clear, a zero ID or the unused code go from idle straight to the response state;
// query or mark run a binary search of at most clog2(count+1) probes; an insert then moves
// each entry from the insert point up by one word before writing the new ID.
// Throughput: one transaction at a time, set by the sequencer and the single RAM port pair.
// Reset: both counts cleared at once; list storage is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
// sorted_unique_id_set_unit: two sorted, duplicate-free ID lists
// Mark, query and clear over wave and pcm ID lists kept in one shared RAM,
// with an output register between the sequencer and the response channel.
// ----------------------------------------------------------------------------
module sorted_unique_id_set_unit
    import suis_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    ram_req_t           ram_req;
    logic [ID_BITS-1:0] ram_rdata;
    logic               res_valid;
    rsp_t               res;
    logic               res_ready;
    logic               rsp_valid_reg;
    rsp_t               rsp_reg;

    suis_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .req_stall (req_stall),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready)
    );

    suis_ram #(
        .DEPTH (RAM_DEPTH),
        .WIDTH (ID_BITS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    // Output register: free when empty or being taken
    assign res_ready = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            rsp_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[hw/rtl/suis_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suis_checker: port-level checks for the sorted unique ID set
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module suis_checker
    import suis_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input req_t req,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    localparam logic [LCOUNT_W-1:0] CAP_COUNT = LCOUNT_W'(CAPACITY);

    // Held response stays put
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // One transaction at a time: busy right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while a transaction is in flight");

    // A refused mark reports a full list and no insert
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.full_error |->
            rsp.list_count == CAP_COUNT && !rsp.inserted && !rsp.was_present)
        else $error("full error with inconsistent response fields");

    // No response comes out of reset
    a_reset: assert property (@(posedge clk)
        !rst_n |-> !rsp_valid)
        else $error("response valid during reset");

endmodule

bind sorted_unique_id_set_unit suis_checker u_suis_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
